@@ rtl/core/ipv4_dotted_quad_parser_unit_defines.svh @@
// Assertion macros for the dotted-quad parser.
// Included by ipv4_dotted_quad_parser_unit; no other dependencies.
`ifndef IPV4_DOTTED_QUAD_PARSER_UNIT_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPV4DQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipv4dq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPV4DQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipv4dq: next-cycle check failed");

`endif

@@ rtl/core/ipv4dq_pkg.sv @@
// Shared types and character constants for the dotted-quad parser.
// No dependencies.
package ipv4dq_pkg;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [11:0] OCTET_MAX = 12'd255;

    typedef struct packed {
        logic [7:0]      acc;
        logic [1:0]      dots;
        logic [2:0][7:0] stored;
        logic            err;
        logic            nonblank;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_CLEAR = '0;

endpackage

@@ rtl/core/ipv4dq_char_step.sv @@
// Per-character state update of the dotted-quad parser (combinational).
// Depends on ipv4dq_pkg.
module ipv4dq_char_step
    import ipv4dq_pkg::*;
(
    input  parse_state_t state_in,
    input  logic [7:0]   char_in,
    output parse_state_t state_out
);

    logic        is_blank;
    logic        is_digit;
    logic [11:0] acc_times_ten;
    logic [11:0] acc_sum;

    assign is_blank = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB) ||
                      (char_in == CHAR_LF) || (char_in == CHAR_CR);
    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);

    // acc*10 = acc*8 + acc*2
    assign acc_times_ten = {1'b0, state_in.acc, 3'b000} + {3'b000, state_in.acc, 1'b0};
    assign acc_sum       = acc_times_ten + {4'b0000, char_in - CHAR_ZERO};

    always_comb begin
        state_out = state_in;
        if (!is_blank) begin
            state_out.nonblank = 1'b1;
        end
        if (!state_in.err) begin
            if (is_digit) begin
                if (acc_sum > OCTET_MAX) begin
                    state_out.err = 1'b1;
                end else begin
                    state_out.acc = acc_sum[7:0];
                end
            end else if (char_in == CHAR_DOT) begin
                if (state_in.dots == 2'd3) begin
                    state_out.err = 1'b1;
                end else begin
                    state_out.stored[state_in.dots] = state_in.acc;
                    state_out.dots = state_in.dots + 2'd1;
                    state_out.acc  = 8'd0;
                end
            end else begin
                state_out.err = 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/ipv4_dotted_quad_parser_unit.sv @@
// Top level of the dotted-quad parser: input register, state, result register.
// Depends on ipv4dq_pkg, ipv4dq_char_step and the assertion header.
//
//  channel | dir | tdata                      | tuser      | tlast
//  s_      | in  | [7:0] character            | -          | is_last
//  m_      | out | octets first..fourth, LSB  | [1:0] stat | -
//
// One character per cycle is accepted while no last character stalls; a character
// is applied from the input register through the per-character update.
// A result is written to the result register as the last character leaves the
// input register, and it sits there until taken.
// Only a last character stalls, when the output register is occupied and not
// being taken in the same cycle.
// aresetn (synchronous, active low) clears all parse state and valid flags.
`include "ipv4_dotted_quad_parser_unit_defines.svh"

module ipv4_dotted_quad_parser_unit
    import ipv4dq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] octet_first, [15:8] octet_second,
                                   // [23:16] octet_third, [31:24] octet_fourth
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_last_reg;

    parse_state_t state_reg, state_next, state_stepped;

    logic         out_valid_reg;
    status_t      out_status_reg, out_status_next;
    logic [31:0]  out_data_reg, out_data_next;

    logic         advance;
    logic         result_load;

    ipv4dq_char_step u_char_step (
        .state_in  (state_reg),
        .char_in   (in_char_reg),
        .state_out (state_stepped)
    );

    // a non-last character never needs the output register
    assign advance     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign result_load = advance && in_last_reg;
    assign s_tready    = !in_valid_reg || advance;

    always_comb begin
        state_next      = state_reg;
        out_status_next = STATUS_INVALID;
        out_data_next   = 32'd0;
        if (!state_stepped.nonblank) begin
            out_status_next = STATUS_MISSING;
        end else if (state_stepped.err || (state_stepped.dots != 2'd3)) begin
            out_status_next = STATUS_INVALID;
        end else begin
            out_status_next = STATUS_OK;
            out_data_next   = {state_stepped.acc, state_stepped.stored[2],
                               state_stepped.stored[1], state_stepped.stored[0]};
        end
        if (advance) begin
            state_next = in_last_reg ? PARSE_STATE_CLEAR : state_stepped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_STATE_CLEAR;
        end else begin
            state_reg <= state_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (result_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (result_load) begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `IPV4DQ_ASSERT_NOW(a_octets_zero_unless_ok, aclk, aresetn,
        m_tvalid && (m_tuser != STATUS_OK), m_tdata == 32'd0)
    `IPV4DQ_ASSERT_NEXT(a_state_cleared_after_last, aclk, aresetn,
        result_load, (state_reg.dots == 2'd0) && !state_reg.err &&
        !state_reg.nonblank && (state_reg.acc == 8'd0))
    `IPV4DQ_ASSERT_NOW(a_last_stalls_on_full_output, aclk, aresetn,
        in_valid_reg && in_last_reg && m_tvalid && !m_tready, !s_tready && !advance)

endmodule
